### rtl/core/wsdt_pkg.sv
// Shared constants, types and controller/datapath interface structs
// for the weighted score dominance test block. No dependencies.
`default_nettype none

package wsdt_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int MAX_ROWS   = 8;
    localparam int COORD_BITS = 16;

    // register and field widths
    localparam int CFG_DIMS_W = 3;
    localparam int CFG_ROWS_W = 4;
    localparam int CFG_DATA_W = 4;
    localparam int ROW_IDX_W  = 3;
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int LEAST_W    = 2 * COORD_BITS + 3;

    localparam int DIM_CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int ROW_AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int WROW_W     = MAX_DIMS * COORD_BITS;

    // stream packing
    localparam int IN_A_LSB    = ROW_IDX_W;
    localparam int IN_B_LSB    = IN_A_LSB + WROW_W;
    localparam int S_DATA_BITS = IN_B_LSB + WROW_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = 1 + LEAST_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;

    // reset values
    localparam logic [CFG_DIMS_W-1:0] DIMS_RESET = CFG_DIMS_W'(4);
    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(8);

    // opcodes and register indexes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;
    localparam logic CFG_IDX_DIMS = 1'b0;
    localparam logic CFG_IDX_ROWS = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [PROD_W-1:0]     prod_t;
    typedef logic [LEAST_W-1:0]    score_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WAIT_OUT
    } state_t;

    typedef struct packed {
        logic start_load;
        logic start_test;
        logic issue;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/wsdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wsdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/wsdt_ctrl.sv
// Sequencer for load and test transactions: scans weight rows and
// hands results to the output register. Depends on wsdt_pkg.
`default_nettype none

module wsdt_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tuser,
    output logic                      s_tready,
    input  wire wsdt_pkg::dp_status_t status,
    output wsdt_pkg::dp_cmd_t         cmd
);
    import wsdt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == OP_LOAD) begin
                        cmd.start_load = 1'b1;
                        state_next     = ST_WAIT_OUT;
                    end else begin
                        cmd.start_test = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_WAIT_OUT;
                end
            end
            ST_WAIT_OUT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/wsdt_datapath.sv
// Datapath: config registers, weight table, dot-product pipeline,
// score accumulators and output register. Depends on wsdt_pkg, wsdt_ram.
`default_nettype none

module wsdt_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire wsdt_pkg::dp_cmd_t                   cmd,
    output wsdt_pkg::dp_status_t                     status,
    input  wire logic [wsdt_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_index,
    input  wire logic [wsdt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic      [wsdt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import wsdt_pkg::*;

    logic [CFG_DIMS_W-1:0] dims_reg;
    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [DIM_CNT_W-1:0]  dims_eff;
    logic [ROW_CNT_W-1:0]  rows_eff;

    coord_t                a_reg [MAX_DIMS];
    coord_t                b_reg [MAX_DIMS];
    logic [ROW_AW-1:0]     row_cnt_reg;
    logic                  v1_reg, v2_reg;
    logic [WROW_W-1:0]     wrow;
    prod_t                 prod_a_reg [MAX_DIMS];
    prod_t                 prod_b_reg [MAX_DIMS];
    score_t                sum_a, sum_b;
    score_t                least_reg;
    logic                  greater_reg, strict_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [ROW_IDX_W-1:0]  ld_idx;
    logic                  ram_we;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= DIMS_RESET;
            rows_reg <= ROWS_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_IDX_DIMS) begin
                dims_reg <= cfg_wdata[CFG_DIMS_W-1:0];
            end else begin
                rows_reg <= cfg_wdata[CFG_ROWS_W-1:0];
            end
        end
    end

    // clamp to 1..MAX
    always_comb begin
        if (dims_reg == '0) begin
            dims_eff = DIM_CNT_W'(1);
        end else if (int'(dims_reg) > MAX_DIMS) begin
            dims_eff = DIM_CNT_W'(MAX_DIMS);
        end else begin
            dims_eff = DIM_CNT_W'(dims_reg);
        end
        if (rows_reg == '0) begin
            rows_eff = ROW_CNT_W'(1);
        end else if (int'(rows_reg) > MAX_ROWS) begin
            rows_eff = ROW_CNT_W'(MAX_ROWS);
        end else begin
            rows_eff = ROW_CNT_W'(rows_reg);
        end
    end

    // weight table
    assign ld_idx = s_tdata[ROW_IDX_W-1:0];
    assign ram_we = cmd.start_load && (int'(ld_idx) < MAX_ROWS);

    wsdt_ram #(
        .WIDTH (WROW_W),
        .DEPTH (MAX_ROWS)
    ) u_wtab (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ROW_AW'(ld_idx)),
        .wdata (s_tdata[IN_A_LSB +: WROW_W]),
        .re    (cmd.issue),
        .raddr (row_cnt_reg),
        .rdata (wrow)
    );

    // tuple capture
    always_ff @(posedge aclk) begin
        if (cmd.start_test) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                a_reg[i] <= s_tdata[IN_A_LSB + i*COORD_BITS +: COORD_BITS];
                b_reg[i] <= s_tdata[IN_B_LSB + i*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // row counter and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.start_test) begin
                row_cnt_reg <= '0;
            end else if (cmd.issue) begin
                row_cnt_reg <= row_cnt_reg + ROW_AW'(1);
            end
        end
    end

    // stage 1: products, unused coordinates forced to zero
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                if (DIM_CNT_W'(i) < dims_eff) begin
                    prod_a_reg[i] <= a_reg[i] * wrow[i*COORD_BITS +: COORD_BITS];
                    prod_b_reg[i] <= b_reg[i] * wrow[i*COORD_BITS +: COORD_BITS];
                end else begin
                    prod_a_reg[i] <= '0;
                    prod_b_reg[i] <= '0;
                end
            end
        end
    end

    // stage 2: row scores
    always_comb begin
        sum_a = '0;
        sum_b = '0;
        for (int i = 0; i < MAX_DIMS; i++) begin
            sum_a = sum_a + LEAST_W'(prod_a_reg[i]);
            sum_b = sum_b + LEAST_W'(prod_b_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_load) begin
            least_reg   <= '0;
            greater_reg <= 1'b0;
            strict_reg  <= 1'b0;
        end else if (cmd.start_test) begin
            least_reg   <= LEAST_W'(dims_eff) << PROD_W;
            greater_reg <= 1'b0;
            strict_reg  <= 1'b0;
        end else if (v2_reg) begin
            if (sum_a < least_reg) begin
                least_reg <= sum_a;
            end
            if (!greater_reg) begin
                if (sum_a > sum_b) begin
                    greater_reg <= 1'b1;
                end else if (sum_a < sum_b) begin
                    strict_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({least_reg, (!greater_reg && strict_reg)});
        end
    end

    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;
    assign status.last_issue = (ROW_CNT_W'(row_cnt_reg) == rows_eff - ROW_CNT_W'(1));
    assign status.pipe_busy  = v1_reg || v2_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

### rtl/core/weighted_score_dominance_test.sv
// Top level of the weighted score dominance test block.
// Depends on wsdt_pkg, wsdt_ctrl, wsdt_datapath (and wsdt_ram below it).
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tuser = opcode, s_tdata = row index, A, B
//  m_*       out  m_tvalid/m_tready   m_tdata = dominates, least_score
//  cfg_*     in   cfg_wr_en           cfg_index selects dims / rows register
//
// Sequence: a load result is registered through the output-wait state, a test result
// through row reads, multiply, accumulate, pipeline-empty check and output register;
// the sequencer then returns to idle and accepts the next transaction.
// Reset (synchronous, aresetn low) clears sequencer, output valid and config; not the table.
// Stalls: the next transaction is accepted while a result waits for m_tready; the
// sequencer then holds its own result until the output slot frees.
`default_nettype none

module weighted_score_dominance_test (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // bits: [2:0] row_index, [18:3] vec_a_0, [34:19] vec_a_1, [50:35] vec_a_2,
    // [66:51] vec_a_3, [82:67] vec_b_0, [98:83] vec_b_1, [114:99] vec_b_2,
    // [130:115] vec_b_3, rest zero
    input  wire logic [wsdt_pkg::S_TDATA_W-1:0]      s_tdata,
    // bit 0: opcode (0 load row, 1 test)
    input  wire logic                                s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // bits: [0] dominates, [35:1] least_score, rest zero
    output logic      [wsdt_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_index,
    input  wire logic [wsdt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import wsdt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    wsdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wsdt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/core/wsdt_checker.sv
// Port-level checks for the weighted score dominance test block,
// bound to the top level. Depends on wsdt_pkg.
`default_nettype none

module wsdt_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [wsdt_pkg::M_TDATA_W-1:0]    m_tdata
);
    import wsdt_pkg::*;

    localparam score_t LEAST_MAX = LEAST_W'(MAX_DIMS) << PROD_W;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction at a time: ready drops after accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    // a load with a free output slot gives a zero result after the output-wait state and output register
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_LOAD) && !m_tvalid
        |=> ##1 m_tvalid && (m_tdata == '0))
        else $error("load result missing or nonzero");

    // least score never above the largest start value, MAX_DIMS << PROD_W
    a_least: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[LEAST_W:1] <= LEAST_MAX))
        else $error("least score out of range");

endmodule

bind weighted_score_dominance_test wsdt_checker u_wsdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
